@@ hdl/bmsirq_pkg.sv @@
// Package for the bank mapper with scanline interrupt counter.
// Holds operation codes, register write decode codes and the bank mask helper.
// No dependencies.
package bmsirq_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ValueW  = 8;
  localparam int unsigned OffsetW = 21;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned NumBank = 8;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_TICK      = 2'd1,
    OP_PRG_XLATE = 2'd2,
    OP_CHR_XLATE = 2'd3
  } op_e;

  // Write decode key: address bits 15..13 and bit 0.
  localparam logic [3:0] WR_SELECT   = 4'b1000;
  localparam logic [3:0] WR_BANK     = 4'b1001;
  localparam logic [3:0] WR_MIRROR   = 4'b1010;
  localparam logic [3:0] WR_PROTECT  = 4'b1011;
  localparam logic [3:0] WR_LATCH    = 4'b1100;
  localparam logic [3:0] WR_CLEAR    = 4'b1101;
  localparam logic [3:0] WR_IRQ_OFF  = 4'b1110;
  localparam logic [3:0] WR_IRQ_ON   = 4'b1111;

  // Configuration register indexes.
  localparam logic CFG_PRG_BITS = 1'b0;
  localparam logic CFG_CHR_BITS = 1'b1;

  localparam logic [ValueW-1:0] BANK_SECOND_LAST = 8'hFE;
  localparam logic [ValueW-1:0] BANK_LAST        = 8'hFF;

  // Mask for a power-of-two bank count; counts above 8 bits saturate.
  function automatic logic [ValueW-1:0] bank_mask(input logic [BitsW-1:0] bits);
    logic [3:0] b;
    logic [8:0] m;
    b = (bits > 4'd8) ? 4'd8 : bits;
    m = (9'd1 << b) - 9'd1;
    return m[ValueW-1:0];
  endfunction

endpackage

@@ hdl/bank_mapper_scanline_irq_unit.sv @@
// Bank mapper with scanline interrupt counter: one module, two register stages.
// Each beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_ready_i is not held low; the mapper state
// updates as an item leaves the input register, so the next item sees it at once.
// Reset: asynchronous, active low; bank state clears, mirroring resets horizontal,
// program bank bits reset to 1 and character bank bits to 3.
module bank_mapper_scanline_irq_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [bmsirq_pkg::BitsW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [bmsirq_pkg::AddrW-1:0]   address_i,
  input  logic [bmsirq_pkg::ValueW-1:0]  value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           irq_line_o,
  output logic                           mirror_horizontal_o,
  output logic                           mapped_valid_o,
  output logic [bmsirq_pkg::OffsetW-1:0] mapped_address_o
);
  import bmsirq_pkg::*;

  // Configuration.
  logic [BitsW-1:0] prg_bits_q, chr_bits_q;

  // Input register.
  logic              in_valid_q;
  logic [1:0]        op_q;
  logic [AddrW-1:0]  addr_q;
  logic [ValueW-1:0] value_q;

  // Mapper state.
  logic [ValueW-1:0] select_q, select_d;
  logic [ValueW-1:0] bank_q [NumBank];
  logic [ValueW-1:0] bank_d [NumBank];
  logic [ValueW-1:0] reload_q, reload_d;
  logic [ValueW-1:0] count_q, count_d;
  logic              irq_on_q, irq_on_d;
  logic              pending_q, pending_d;
  logic              mirror_q, mirror_d;

  // Result register.
  logic               out_valid_q;
  logic               irq_q, mir_out_q, mvalid_q;
  logic [OffsetW-1:0] maddr_q;

  logic               advance;
  logic               xl_valid;
  logic [OffsetW-1:0] xl_addr;
  logic [3:0]         wr_key;
  logic [ValueW-1:0]  prg_bank, chr_bank;
  logic [12:0]        chr_a;
  logic [2:0]         slot;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign wr_key     = {addr_q[15:13], addr_q[0]};

  always_comb begin
    select_d  = select_q;
    bank_d    = bank_q;
    reload_d  = reload_q;
    count_d   = count_q;
    irq_on_d  = irq_on_q;
    pending_d = pending_q;
    mirror_d  = mirror_q;
    case (op_q)
      OP_CPU_WRITE: begin
        if (addr_q[15]) begin
          case (wr_key)
            WR_SELECT:  select_d = value_q;
            WR_BANK:    bank_d[select_q[2:0]] = value_q;
            WR_MIRROR:  mirror_d = value_q[0];
            WR_LATCH:   reload_d = value_q;
            WR_CLEAR:   count_d = '0;
            WR_IRQ_OFF: begin
              irq_on_d  = 1'b0;
              pending_d = 1'b0;
            end
            WR_IRQ_ON:  irq_on_d = 1'b1;
            default:    ;
          endcase
        end
      end
      OP_TICK: begin
        count_d = (count_q == '0) ? reload_q : count_q - 8'd1;
        if (irq_on_q && count_d == '0) begin
          pending_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Program window: bit 6 of select swaps the first and third windows.
  always_comb begin
    case (addr_q[14:13])
      2'd0:    prg_bank = select_q[6] ? BANK_SECOND_LAST : bank_q[6];
      2'd1:    prg_bank = bank_q[7];
      2'd2:    prg_bank = select_q[6] ? bank_q[6] : BANK_SECOND_LAST;
      default: prg_bank = BANK_LAST;
    endcase
  end

  // Character window: bit 7 of select swaps the two 4 KB halves.
  assign chr_a = {addr_q[12] ^ select_q[7], addr_q[11:0]};
  assign slot  = chr_a[12:10];

  always_comb begin
    case (slot)
      3'd0:    chr_bank = {bank_q[0][7:1], 1'b0};
      3'd1:    chr_bank = {bank_q[0][7:1], 1'b1};
      3'd2:    chr_bank = {bank_q[1][7:1], 1'b0};
      3'd3:    chr_bank = {bank_q[1][7:1], 1'b1};
      3'd4:    chr_bank = bank_q[2];
      3'd5:    chr_bank = bank_q[3];
      3'd6:    chr_bank = bank_q[4];
      default: chr_bank = bank_q[5];
    endcase
  end

  always_comb begin
    xl_valid = 1'b0;
    xl_addr  = '0;
    case (op_q)
      OP_PRG_XLATE: begin
        if (addr_q[15]) begin
          xl_valid = 1'b1;
          xl_addr  = {prg_bank & bank_mask(prg_bits_q), addr_q[12:0]};
        end
      end
      OP_CHR_XLATE: begin
        if (addr_q[15:13] == 3'd0) begin
          xl_valid = 1'b1;
          xl_addr  = {3'd0, chr_bank & bank_mask(chr_bits_q), addr_q[9:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bits_q <= 4'd1;
      chr_bits_q <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRG_BITS: prg_bits_q <= cfg_data_i;
        CFG_CHR_BITS: chr_bits_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q    <= operation_i;
      addr_q  <= address_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q  <= '0;
      bank_q    <= '{default: '0};
      reload_q  <= '0;
      count_q   <= '0;
      irq_on_q  <= 1'b0;
      pending_q <= 1'b0;
      mirror_q  <= 1'b1;
    end else if (advance) begin
      select_q  <= select_d;
      bank_q    <= bank_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
      irq_on_q  <= irq_on_d;
      pending_q <= pending_d;
      mirror_q  <= mirror_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      irq_q     <= pending_d;
      mir_out_q <= mirror_d;
      mvalid_q  <= xl_valid;
      maddr_q   <= xl_addr;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign irq_line_o          = irq_q;
  assign mirror_horizontal_o = mir_out_q;
  assign mapped_valid_o      = mvalid_q;
  assign mapped_address_o    = maddr_q;

endmodule

@@ tb/bank_mapper_scanline_irq_unit_tb.sv @@
// Self-checking testbench for bank_mapper_scanline_irq_unit.
// It predicts every result beat from its own mapper model and checks it, with random idling.
// Depends on bmsirq_pkg and the block's RTL.
`timescale 1ns / 100ps

module bank_mapper_scanline_irq_unit_tb;
  import bmsirq_pkg::*;

  localparam int unsigned BeatsPerPhase = 175;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned TailCycles    = 12;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0]  addr;
    logic [ValueW-1:0] data;
  } bus_beat_t;

  typedef struct packed {
    logic               irq;
    logic               mirror;
    logic               hit;
    logic [OffsetW-1:0] offset;
  } mapper_resp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we_i    = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic [BitsW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = '0;
  logic [AddrW-1:0]   address_i   = '0;
  logic [ValueW-1:0]  value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               irq_line_o;
  logic               mirror_horizontal_o;
  logic               mapped_valid_o;
  logic [OffsetW-1:0] mapped_address_o;

  bank_mapper_scanline_irq_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .address_i          (address_i),
    .value_i            (value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .irq_line_o         (irq_line_o),
    .mirror_horizontal_o(mirror_horizontal_o),
    .mapped_valid_o     (mapped_valid_o),
    .mapped_address_o   (mapped_address_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mapper model state, at its reset values.
  logic [ValueW-1:0] mdl_select  = '0;
  logic [ValueW-1:0] mdl_banks [NumBank] = '{default: '0};
  logic [ValueW-1:0] mdl_reload  = '0;
  logic [ValueW-1:0] mdl_count   = '0;
  logic              mdl_irq_on  = 1'b0;
  logic              mdl_pending = 1'b0;
  logic              mdl_mirror  = 1'b1;
  logic [BitsW-1:0]  mdl_prg_bits = 4'd1;
  logic [BitsW-1:0]  mdl_chr_bits = 4'd3;

  bus_beat_t    pending_beats[$];
  mapper_resp_t mapper_responses_due[$];
  bus_beat_t    cur_beat;

  int unsigned beats_queued   = 0;
  int unsigned beats_accepted = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned send_steady    = 0;
  int unsigned recv_gap       = 0;
  int unsigned recv_steady    = 0;

  // Bank count mask; anything above eight bits keeps all eight.
  function automatic logic [ValueW-1:0] window_mask(input logic [BitsW-1:0] bits);
    logic [ValueW-1:0] mask;
    mask = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (i < bits) mask[i] = 1'b1;
    end
    return mask;
  endfunction

  // Applies one beat to the mapper model and returns the result it should produce.
  function automatic mapper_resp_t step_mapper(input bus_beat_t b);
    mapper_resp_t      resp;
    logic [ValueW-1:0] bank;
    logic [12:0]       chr_addr;
    logic [2:0]        slot;
    resp = '0;
    case (b.op)
      OP_CPU_WRITE: begin
        if (b.addr[15]) begin
          case ({b.addr[15:13], b.addr[0]})
            WR_SELECT:  mdl_select = b.data;
            WR_BANK:    mdl_banks[mdl_select[2:0]] = b.data;
            WR_MIRROR:  mdl_mirror = b.data[0];
            WR_LATCH:   mdl_reload = b.data;
            WR_CLEAR:   mdl_count = '0;
            WR_IRQ_OFF: begin
              mdl_irq_on  = 1'b0;
              mdl_pending = 1'b0;
            end
            WR_IRQ_ON:  mdl_irq_on = 1'b1;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (mdl_count == '0) mdl_count = mdl_reload;
        else mdl_count = mdl_count - 8'd1;
        if (mdl_irq_on && mdl_count == '0) mdl_pending = 1'b1;
      end
      OP_PRG_XLATE: begin
        if (b.addr[15]) begin
          case (b.addr[14:13])
            2'd0:    bank = mdl_select[6] ? BANK_SECOND_LAST : mdl_banks[6];
            2'd1:    bank = mdl_banks[7];
            2'd2:    bank = mdl_select[6] ? mdl_banks[6] : BANK_SECOND_LAST;
            default: bank = BANK_LAST;
          endcase
          resp.hit    = 1'b1;
          resp.offset = {bank & window_mask(mdl_prg_bits), b.addr[12:0]};
        end
      end
      default: begin
        if (b.addr[15:13] == 3'd0) begin
          // Select bit 7 swaps the 2 KB pair half with the 1 KB half.
          chr_addr = b.addr[12:0] ^ {mdl_select[7], 12'h000};
          slot     = chr_addr[12:10];
          case (slot)
            3'd0:    bank = {mdl_banks[0][7:1], 1'b0};
            3'd1:    bank = {mdl_banks[0][7:1], 1'b1};
            3'd2:    bank = {mdl_banks[1][7:1], 1'b0};
            3'd3:    bank = {mdl_banks[1][7:1], 1'b1};
            default: bank = mdl_banks[slot - 3'd2];
          endcase
          resp.hit    = 1'b1;
          resp.offset = {3'b000, bank & window_mask(mdl_chr_bits), b.addr[9:0]};
        end
      end
    endcase
    resp.irq    = mdl_pending;
    resp.mirror = mdl_mirror;
    return resp;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned next_gap(inout int unsigned steady);
    int unsigned r;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) steady = $urandom_range(20, 100);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_beat(input op_e op, input logic [AddrW-1:0] addr,
                            input logic [ValueW-1:0] data);
    bus_beat_t b;
    b.op   = op;
    b.addr = addr;
    b.data = data;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_directed_beats();
    queue_beat(OP_PRG_XLATE, 16'h0000, 8'h00);
    queue_beat(OP_CHR_XLATE, 16'h2000, 8'hFF);
    queue_beat(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
    queue_beat(OP_CPU_WRITE, 16'h8000, 8'h06);
    queue_beat(OP_CPU_WRITE, 16'h8001, 8'hFF);
    queue_beat(OP_CPU_WRITE, 16'h8000, 8'h07);
    queue_beat(OP_CPU_WRITE, 16'h9FFF, 8'h5A);
    queue_beat(OP_PRG_XLATE, 16'h8000, 8'h00);
    queue_beat(OP_PRG_XLATE, 16'hA000, 8'h00);
    queue_beat(OP_PRG_XLATE, 16'hFFFF, 8'h00);
    queue_beat(OP_CPU_WRITE, 16'h8000, 8'hC0);
    queue_beat(OP_PRG_XLATE, 16'h9234, 8'h00);
    queue_beat(OP_PRG_XLATE, 16'hC000, 8'h00);
    queue_beat(OP_CHR_XLATE, 16'h0000, 8'h00);
    queue_beat(OP_CHR_XLATE, 16'h1FFF, 8'h00);
    queue_beat(OP_CPU_WRITE, 16'hA000, 8'h00);
    queue_beat(OP_CPU_WRITE, 16'hA001, 8'hFF);
    queue_beat(OP_CPU_WRITE, 16'hC000, 8'h01);
    queue_beat(OP_CPU_WRITE, 16'hC001, 8'h00);
    queue_beat(OP_CPU_WRITE, 16'hE001, 8'h00);
    queue_beat(OP_TICK,      16'h0000, 8'h00);
    queue_beat(OP_TICK,      16'hFFFF, 8'hFF);
    // Enabling again while the interrupt is pending must leave it pending.
    queue_beat(OP_CPU_WRITE, 16'hE001, 8'h00);
    queue_beat(OP_TICK,      16'h0000, 8'h00);
    queue_beat(OP_CPU_WRITE, 16'hE000, 8'h00);
  endtask

  // Most beats hit the register and window ranges; the rest go anywhere.
  task automatic queue_random_beats(input int unsigned count);
    int unsigned       r;
    logic [AddrW-1:0]  addr;
    logic [ValueW-1:0] data;
    op_e               op;
    for (int unsigned i = 0; i < count; i++) begin
      r    = $urandom_range(0, 99);
      addr = AddrW'($urandom);
      data = ValueW'($urandom);
      if (r < 36) begin
        op = OP_CPU_WRITE;
        if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
        if ({addr[15:13], addr[0]} == WR_LATCH && $urandom_range(0, 1) == 0)
          data = ValueW'($urandom_range(0, 5));
      end else if (r < 56) begin
        op = OP_TICK;
      end else if (r < 78) begin
        op = OP_PRG_XLATE;
        if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
      end else begin
        op = OP_CHR_XLATE;
        if ($urandom_range(0, 9) != 0) addr[15:13] = 3'd0;
      end
      queue_beat(op, addr, data);
    end
  endtask

  task automatic wait_idle();
    while (beats_accepted != beats_queued || mapper_responses_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_bank_bits(input logic [BitsW-1:0] prg, input logic [BitsW-1:0] chr);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_index_i  <= CFG_PRG_BITS;
    cfg_data_i   <= prg;
    mdl_prg_bits = prg;
    @(posedge clk_i);
    cfg_index_i  <= CFG_CHR_BITS;
    cfg_data_i   <= chr;
    mdl_chr_bits = chr;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
  endtask

  // Input side: present queued beats, predict each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        mapper_responses_due.push_back(step_mapper(cur_beat));
        beats_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0 || pending_beats.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          cur_beat    = pending_beats.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= cur_beat.op;
          address_i   <= cur_beat.addr;
          value_i     <= cur_beat.data;
          send_gap    = next_gap(send_steady);
        end
      end
    end
  end

  // Output side: random back-pressure and a field by field check of every beat.
  always @(posedge clk_i or negedge rst_ni) begin
    mapper_resp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (mapper_responses_due.size() == 0) begin
          $display("%0t: result beat with no result expected", $time);
          fail_count++;
        end else begin
          want = mapper_responses_due.pop_front();
          if (irq_line_o !== want.irq) begin
            $display("%0t: irq_line expected %0d, got %0d", $time, want.irq, irq_line_o);
            fail_count++;
          end
          if (mirror_horizontal_o !== want.mirror) begin
            $display("%0t: mirror_horizontal expected %0d, got %0d",
                     $time, want.mirror, mirror_horizontal_o);
            fail_count++;
          end
          if (mapped_valid_o !== want.hit) begin
            $display("%0t: mapped_valid expected %0d, got %0d",
                     $time, want.hit, mapped_valid_o);
            fail_count++;
          end
          if (mapped_address_o !== want.offset) begin
            $display("%0t: mapped_address expected 0x%06h, got 0x%06h",
                     $time, want.offset, mapped_address_o);
            fail_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap = next_gap(recv_steady);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bank_mapper_scanline_irq_unit verification failed");
    $finish;
  end

  initial begin
    logic [BitsW-1:0] prg_settings [7];
    logic [BitsW-1:0] chr_settings [7];
    // Extremes of both registers, values past eight and zero among them.
    prg_settings = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd8, 4'd4, 4'd1};
    chr_settings = '{4'd8, 4'd0, 4'd15, 4'd8, 4'd3, 4'd6, 4'd3};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed_beats();
    queue_random_beats(BeatsPerPhase);
    wait_idle();
    for (int p = 0; p < 7; p++) begin
      set_bank_bits(prg_settings[p], chr_settings[p]);
      queue_random_beats(BeatsPerPhase);
      wait_idle();
    end
    set_bank_bits(BitsW'($urandom_range(0, 15)), BitsW'($urandom_range(0, 15)));
    queue_random_beats(BeatsPerPhase);
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && mapper_responses_due.size() == 0) begin
      $display("bank_mapper_scanline_irq_unit verification clean");
    end else begin
      $display("bank_mapper_scanline_irq_unit verification failed");
    end
    $finish;
  end

endmodule
